[hw/rtl/sacl_pkg.sv]
// Shared types, constants and helpers for the set-associative LRU cache tag store.
`default_nettype none
package sacl_pkg;

  localparam int MAX_SETS   = 256;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_W     = 64;
  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  localparam logic [3:0] SET_BITS_RST    = 4'd4;
  localparam logic [5:0] OFFSET_BITS_RST = 6'd4;
  localparam logic [3:0] WAYS_USED_RST   = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS    = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_WAYS_USED   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OC_HIT   = 2'd0,
    OC_MISS  = 2'd1,
    OC_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic fire;
    logic last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic out_free;
    logic modify;
  } status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_SAT) ? v : v + CNT_W'(1);
  endfunction

  function automatic int floor_log2(input int v);
    int k;
    k = 0;
    while ((k < 31) && ((64'(1) << (k + 1)) <= 64'(v))) begin
      k++;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/sacl_ctrl.sv]
// Access sequencer: clearing pass, word accept, evaluate and second pass of a modify.
`default_nettype none
module sacl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sacl_pkg::status_t status,
  output sacl_pkg::cmd_t         cmd
);

  sacl_pkg::state_t state, state_next;
  logic second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sacl_pkg::ST_CLEAR;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next     = state;
    second_next    = second;
    in_ready       = 1'b0;
    cmd.clear_step = 1'b0;
    cmd.load       = 1'b0;
    cmd.fire       = 1'b0;
    cmd.last       = 1'b0;
    unique case (state)
      sacl_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_next = sacl_pkg::ST_IDLE;
        end
      end
      sacl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          second_next = 1'b0;
          state_next  = sacl_pkg::ST_EVAL;
        end
      end
      sacl_pkg::ST_EVAL: begin
        // result register must be free before the set is updated
        if (status.out_free) begin
          cmd.fire = 1'b1;
          cmd.last = !status.modify || second;
          if (status.modify && !second) begin
            second_next = 1'b1;
          end else begin
            state_next = sacl_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = sacl_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/sacl_datapath.sv]
// Set row memory, tag match, LRU pick, counters, config registers and result register.
`default_nettype none
module sacl_datapath #(
  parameter int MaxSets = sacl_pkg::MAX_SETS,
  parameter int MaxWays = sacl_pkg::MAX_WAYS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire sacl_pkg::cmd_t                      cmd,
  output sacl_pkg::status_t                        status,
  input  wire logic                                cfg_write,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                kind,
  input  wire logic [sacl_pkg::ADDR_W-1:0]         address,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               outcome,
  output logic [sacl_pkg::CNT_W-1:0]               hit_total,
  output logic [sacl_pkg::CNT_W-1:0]               miss_total,
  output logic [sacl_pkg::CNT_W-1:0]               eviction_total,
  output logic                                     last
);

  localparam int IdxW     = $clog2(MaxSets);
  localparam int SetLimit = sacl_pkg::floor_log2(MaxSets);
  localparam int SbW      = $clog2(SetLimit + 1);
  localparam int WayW     = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int WCntW    = $clog2(MaxWays + 1);
  localparam int Lvl      = $clog2(MaxWays);
  localparam int Leaves   = 1 << Lvl;
  localparam int AW       = sacl_pkg::ADDR_W;
  localparam int SW       = sacl_pkg::STAMP_W;
  localparam int CW       = sacl_pkg::CNT_W;

  // config registers
  logic [3:0] set_bits;
  logic [5:0] offset_bits;
  logic [3:0] ways_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= sacl_pkg::SET_BITS_RST;
      offset_bits <= sacl_pkg::OFFSET_BITS_RST;
      ways_used   <= sacl_pkg::WAYS_USED_RST;
    end else if (cfg_write) begin
      unique case (sacl_pkg::cfg_reg_t'(cfg_index))
        sacl_pkg::REG_SET_BITS:    set_bits    <= cfg_data[3:0];
        sacl_pkg::REG_OFFSET_BITS: offset_bits <= cfg_data;
        sacl_pkg::REG_WAYS_USED:   ways_used   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // index and tag of the incoming word
  logic [SbW-1:0]   sb_eff;
  logic [6:0]       tag_shift;
  logic [AW-1:0]    addr_shift;
  logic [AW-1:0]    idx_mask;
  logic [IdxW-1:0]  idx_in;
  logic [AW-1:0]    tag_in;
  logic [WCntW-1:0] nw_eff;

  always_comb begin
    sb_eff     = (int'(set_bits) > SetLimit) ? SbW'(SetLimit) : SbW'(set_bits);
    tag_shift  = 7'(sb_eff) + 7'(offset_bits);
    addr_shift = address >> offset_bits;
    idx_mask   = (AW'(1) << sb_eff) - AW'(1);
    idx_in     = IdxW'(addr_shift & idx_mask);
    tag_in     = tag_shift[6] ? '0 : (address >> tag_shift[5:0]);
    if (ways_used == 4'd0) begin
      nw_eff = WCntW'(1);
    end else if (int'(ways_used) > MaxWays) begin
      nw_eff = WCntW'(MaxWays);
    end else begin
      nw_eff = WCntW'(ways_used);
    end
  end

  // row memory: one row holds every way of a set
  sacl_pkg::line_t [MaxWays-1:0] mem [MaxSets];
  sacl_pkg::line_t [MaxWays-1:0] rd_row;
  sacl_pkg::line_t [MaxWays-1:0] wb_row;
  sacl_pkg::line_t [MaxWays-1:0] row_cur;
  sacl_pkg::line_t [MaxWays-1:0] new_row;

  logic [IdxW-1:0] clr_idx;
  logic [IdxW-1:0] idx_q;
  logic [AW-1:0]   tag_q;
  logic            kind_q;
  logic            use_wb;

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_idx] <= '0;
    end else if (cmd.fire) begin
      mem[idx_q] <= new_row;
    end
    if (cmd.load) begin
      rd_row <= mem[idx_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      use_wb  <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_idx <= clr_idx + IdxW'(1);
      end
      // second access of a modify sees the row just written back
      if (cmd.load) begin
        use_wb <= 1'b0;
      end else if (cmd.fire) begin
        use_wb <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_q  <= idx_in;
      tag_q  <= tag_in;
      kind_q <= kind;
    end
    if (cmd.fire) begin
      wb_row <= new_row;
    end
  end

  assign row_cur = use_wb ? wb_row : rd_row;

  // tag match, lowest way wins
  logic            hit;
  logic [WayW-1:0] hit_way;

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if ((w < int'(nw_eff)) && row_cur[w].valid && (row_cur[w].tag == tag_q)) begin
        hit     = 1'b1;
        hit_way = WayW'(w);
      end
    end
  end

  // LRU pick: min-stamp tree, left (lower way) wins ties
  logic            node_en    [2*Leaves];
  logic [SW-1:0]   node_stamp [2*Leaves];
  logic [WayW-1:0] node_way   [2*Leaves];
  logic [WayW-1:0] lru_way;

  always_comb begin
    for (int n = 0; n < 2 * Leaves; n++) begin
      node_en[n]    = 1'b0;
      node_stamp[n] = '0;
      node_way[n]   = '0;
    end
    for (int i = 0; i < MaxWays; i++) begin
      node_en[Leaves+i]    = (i < int'(nw_eff));
      node_stamp[Leaves+i] = row_cur[i].stamp;
      node_way[Leaves+i]   = WayW'(i);
    end
    for (int n = Leaves - 1; n >= 1; n--) begin
      if (node_en[2*n] && (!node_en[2*n+1] || (node_stamp[2*n] <= node_stamp[2*n+1]))) begin
        node_en[n]    = node_en[2*n];
        node_stamp[n] = node_stamp[2*n];
        node_way[n]   = node_way[2*n];
      end else begin
        node_en[n]    = node_en[2*n+1];
        node_stamp[n] = node_stamp[2*n+1];
        node_way[n]   = node_way[2*n+1];
      end
    end
    lru_way = node_way[1];
  end

  // counters
  logic [SW-1:0] stamp_cnt;
  logic [CW-1:0] hits, misses, evictions;
  logic [CW-1:0] hits_next, misses_next, evictions_next;
  logic [WayW-1:0] way_sel;
  logic            evict;
  sacl_pkg::outcome_t oc;

  always_comb begin
    way_sel = hit ? hit_way : lru_way;
    evict   = !hit && row_cur[lru_way].valid;
    new_row = row_cur;
    new_row[way_sel].stamp = stamp_cnt;
    if (!hit) begin
      new_row[way_sel].valid = 1'b1;
      new_row[way_sel].tag   = tag_q;
    end
    hits_next      = hit ? sacl_pkg::sat_inc(hits) : hits;
    misses_next    = hit ? misses : sacl_pkg::sat_inc(misses);
    evictions_next = evict ? sacl_pkg::sat_inc(evictions) : evictions;
    if (hit) begin
      oc = sacl_pkg::OC_HIT;
    end else if (evict) begin
      oc = sacl_pkg::OC_EVICT;
    end else begin
      oc = sacl_pkg::OC_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_cnt <= SW'(1);
      hits      <= '0;
      misses    <= '0;
      evictions <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.fire) begin
        stamp_cnt <= sacl_pkg::sat_inc(stamp_cnt);
        hits      <= hits_next;
        misses    <= misses_next;
        evictions <= evictions_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      outcome        <= oc;
      hit_total      <= hits_next;
      miss_total     <= misses_next;
      eviction_total <= evictions_next;
      last           <= cmd.last;
    end
  end

  assign status.clear_done = (clr_idx == IdxW'(MaxSets - 1));
  assign status.out_free   = !out_valid || out_ready;
  assign status.modify     = kind_q;

endmodule
`default_nettype wire

[hw/rtl/set_assoc_cache_lru_sim_unit.sv]
// Top level of the set-associative cache tag store with LRU replacement.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   kind, address
//   out      output     out_valid / out_ready outcome, hit_total, miss_total,
//                                             eviction_total, last
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// A load/store word is accepted with its set-row read, then evaluated with row
// writeback; a modify is evaluated twice, its second pass reuses the written-back row.
// Each word reads its row once and writes it back on every pass; no new word is taken
// until the current one is done. After reset a clearing pass writes MaxSets rows before
// in_ready rises; config writes are taken throughout.
// A result waits in the output register; the next evaluate stalls until it is taken.
`default_nettype none
module set_assoc_cache_lru_sim_unit #(
  parameter int MaxSets = sacl_pkg::MAX_SETS,
  parameter int MaxWays = sacl_pkg::MAX_WAYS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            kind,
  input  wire logic [sacl_pkg::ADDR_W-1:0]     address,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           outcome,
  output logic [sacl_pkg::CNT_W-1:0]           hit_total,
  output logic [sacl_pkg::CNT_W-1:0]           miss_total,
  output logic [sacl_pkg::CNT_W-1:0]           eviction_total,
  output logic                                 last
);

  sacl_pkg::cmd_t    cmd;
  sacl_pkg::status_t status;

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sacl_datapath #(
    .MaxSets (MaxSets),
    .MaxWays (MaxWays)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .kind           (kind),
    .address        (address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .outcome        (outcome),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total),
    .last           (last)
  );

endmodule
`default_nettype wire
